@@ sv/hhp_pkg.sv @@
// Shared types and constants of the heading-hold PID speed splitter.
// Used by the divider, the datapath, the controller and the top level.
package hhp_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP        = 3'd0,
    REG_KI        = 3'd1,
    REG_KD        = 3'd2,
    REG_ILIM      = 3'd3,
    REG_MIN_SPEED = 3'd4,
    REG_MAX_SPEED = 3'd5
  } hhp_reg_e;

  // Register reset values.
  localparam logic [15:0] KP_RESET        = 16'd1280;
  localparam logic [15:0] KI_RESET        = 16'd3;
  localparam logic [15:0] KD_RESET        = 16'd26;
  localparam logic [30:0] ILIM_RESET      = 31'd1000000;
  localparam logic [7:0]  MIN_SPEED_RESET = 8'd100;
  localparam logic [7:0]  MAX_SPEED_RESET = 8'd255;

  // Arithmetic constants.
  localparam logic signed [16:0] WRAP_HI    = 17'sd18000;
  localparam logic signed [16:0] WRAP_SPAN  = 17'sd36000;
  localparam logic [15:0]        DT_DEFAULT = 16'd10;
  localparam logic signed [16:0] RATE_SCALE = 17'sd1000;
  localparam logic [15:0]        KI_SCALE   = 16'd1000;
  localparam logic [15:0]        OUT_SCALE  = 16'd25600;
  localparam logic [8:0]         CORR_MAX   = 9'd255;

  // Datapath widths.
  localparam int unsigned MUL_A_W   = 33;
  localparam int unsigned MUL_B_W   = 17;
  localparam int unsigned PROD_W    = 50;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned RATE_W    = 28;
  localparam int unsigned DIV_W     = 48;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned DIV_STEP_BITS = 4;

  typedef struct packed {
    logic signed [15:0] target_heading;
    logic signed [15:0] measured_heading;
    logic [15:0]        elapsed_ms;
    logic [7:0]         base_speed;
    logic               restart;
  } hhp_in_t;

  typedef struct packed {
    logic signed [8:0] correction;
    logic [7:0]        left_speed;
    logic [7:0]        right_speed;
  } hhp_out_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_EDT,
    OP_ACC,
    OP_MUL_DIFF,
    OP_DIV_RATE,
    OP_MUL_KI,
    OP_DIV_KI,
    OP_MUL_KP,
    OP_MUL_KD,
    OP_ADD,
    OP_DIV_SUM,
    OP_OUT
  } hhp_op_e;

  typedef struct packed {
    hhp_op_e op;
  } hhp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } hhp_status_t;

endpackage

@@ sv/hhp_stream_if.sv @@
// Valid/ready stream interface used for the tick and result channels.
// The payload type is set by the instantiating level, normally a struct from hhp_pkg.
interface hhp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/hhp_div.sv @@
// Iterative unsigned restoring divider, several quotient bits per cycle.
// Depends on hhp_pkg for default widths.
module hhp_div #(
  parameter int unsigned W        = hhp_pkg::DIV_W,
  parameter int unsigned DW       = hhp_pkg::DIVISOR_W,
  parameter int unsigned StepBits = hhp_pkg::DIV_STEP_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [W-1:0]  quotient_o
);
  import hhp_pkg::*;

  localparam int unsigned Steps = W / StepBits;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [W-1:0]    quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   divisor_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  always_comb begin
    logic [DW:0] trial;
    trial = '0;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < StepBits; i++) begin
      trial = {rem_d, quo_d[W-1]};
      quo_d = {quo_d[W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_q}) begin
        trial    = trial - {1'b0, divisor_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(Steps);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ sv/hhp_datapath.sv @@
// Datapath of the heading-hold PID: configuration, state, shared multiplier and divider.
// Depends on hhp_pkg and instantiates hhp_div; steered by hhp_ctrl through hhp_cmd_t.
module hhp_datapath #(
  parameter int unsigned DivStepBits = hhp_pkg::DIV_STEP_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  hhp_pkg::hhp_in_t                in_data_i,
  input  logic                            cfg_we_i,
  input  logic [hhp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hhp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  hhp_pkg::hhp_cmd_t               cmd_i,
  output hhp_pkg::hhp_status_t            status_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output hhp_pkg::hhp_out_t               out_data_o
);
  import hhp_pkg::*;

  function automatic logic [7:0] clamp_speed(logic signed [10:0] x, logic [7:0] lo,
                                             logic [7:0] hi);
    logic [7:0] r;
    if (x < $signed({3'b000, lo})) begin
      r = lo;
    end else if (x > $signed({3'b000, hi})) begin
      r = hi;
    end else begin
      r = x[7:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [15:0] kp_q, ki_q, kd_q;
  logic [30:0] ilim_q;
  logic [7:0]  min_q, max_q;

  // Controller state carried between ticks.
  logic signed [31:0] integ_q;
  logic signed [15:0] prev_q;

  // Per-tick working registers.
  logic signed [15:0]       e_q;
  logic [15:0]              dt_q;
  logic [7:0]               base_q;
  logic signed [16:0]       diff_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [RATE_W-1:0] rate_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [8:0]        corr_q;
  logic                     div_neg_q;
  hhp_op_e                  div_dst_q;
  logic                     out_valid_q;
  hhp_out_t                 out_data_q;

  // Load-time arithmetic.
  logic signed [16:0] raw_diff, wrapped, prev_eff;
  logic signed [15:0] e_d;
  logic [15:0]        dt_d;

  assign raw_diff = 17'(in_data_i.target_heading) - 17'(in_data_i.measured_heading);

  always_comb begin
    if (raw_diff > WRAP_HI) begin
      wrapped = raw_diff - WRAP_SPAN;
    end else if (raw_diff <= -WRAP_HI) begin
      wrapped = raw_diff + WRAP_SPAN;
    end else begin
      wrapped = raw_diff;
    end
  end

  assign e_d      = wrapped[15:0];
  assign prev_eff = in_data_i.restart ? 17'sd0 : 17'(prev_q);
  assign dt_d     = (in_data_i.elapsed_ms == 16'd0) ? DT_DEFAULT : in_data_i.elapsed_ms;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_EDT: begin
        mul_a = MUL_A_W'(e_q);
        mul_b = $signed({1'b0, dt_q});
      end
      OP_MUL_DIFF: begin
        mul_a = MUL_A_W'(diff_q);
        mul_b = RATE_SCALE;
      end
      OP_MUL_KI: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = $signed({1'b0, ki_q});
      end
      OP_MUL_KP: begin
        mul_a = MUL_A_W'(e_q);
        mul_b = $signed({1'b0, kp_q});
      end
      OP_MUL_KD: begin
        mul_a = MUL_A_W'(rate_q);
        mul_b = $signed({1'b0, kd_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integral update with clamp; the product e*dt always fits 34 bits.
  logic signed [33:0] acc_sum, lim34, acc_clamped;

  assign acc_sum = 34'(integ_q) + $signed(prod_q[33:0]);
  assign lim34   = $signed({3'b000, ilim_q});

  always_comb begin
    if (acc_sum > lim34) begin
      acc_clamped = lim34;
    end else if (acc_sum < -lim34) begin
      acc_clamped = -lim34;
    end else begin
      acc_clamped = acc_sum;
    end
  end

  // Divider operands: magnitude in, sign restored on the way out.
  logic                     div_start, div_done;
  logic signed [PROD_W-1:0] div_src, div_mag;
  logic [DIVISOR_W-1:0]     div_divisor;
  logic [DIV_W-1:0]         div_quo;
  logic signed [DIV_W-1:0]  quo_signed;
  logic [8:0]               corr_mag;

  assign div_start = cmd_i.op inside {OP_DIV_RATE, OP_DIV_KI, OP_DIV_SUM};

  always_comb begin
    case (cmd_i.op)
      OP_DIV_RATE: begin
        div_src     = prod_q;
        div_divisor = dt_q;
      end
      OP_DIV_KI: begin
        div_src     = prod_q;
        div_divisor = KI_SCALE;
      end
      OP_DIV_SUM: begin
        div_src     = PROD_W'(sum_q);
        div_divisor = OUT_SCALE;
      end
      default: begin
        div_src     = '0;
        div_divisor = '0;
      end
    endcase
  end

  assign div_mag = (div_src < 0) ? -div_src : div_src;

  hhp_div #(
    .W        (DIV_W),
    .DW       (DIVISOR_W),
    .StepBits (DivStepBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_mag[DIV_W-1:0]),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign quo_signed = div_neg_q ? -$signed(div_quo) : $signed(div_quo);
  assign corr_mag   = (div_quo > DIV_W'(CORR_MAX)) ? CORR_MAX : div_quo[8:0];

  // Output stage.
  logic               out_free;
  logic signed [10:0] left_x, right_x;

  assign out_free = !out_valid_q || out_ready_i;
  assign left_x   = $signed({3'b000, base_q}) + 11'(corr_q);
  assign right_x  = $signed({3'b000, base_q}) - 11'(corr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= KP_RESET;
      ki_q        <= KI_RESET;
      kd_q        <= KD_RESET;
      ilim_q      <= ILIM_RESET;
      min_q       <= MIN_SPEED_RESET;
      max_q       <= MAX_SPEED_RESET;
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (hhp_reg_e'(cfg_idx_i))
          REG_KP:        kp_q   <= cfg_data_i[15:0];
          REG_KI:        ki_q   <= cfg_data_i[15:0];
          REG_KD:        kd_q   <= cfg_data_i[15:0];
          REG_ILIM:      ilim_q <= cfg_data_i;
          REG_MIN_SPEED: min_q  <= cfg_data_i[7:0];
          REG_MAX_SPEED: max_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (load_i) begin
        prev_q <= e_d;
        if (in_data_i.restart) begin
          integ_q <= '0;
        end
      end else if (cmd_i.op == OP_ACC) begin
        integ_q <= acc_clamped[31:0];
      end
      if (cmd_i.op == OP_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      e_q    <= e_d;
      dt_q   <= dt_d;
      base_q <= in_data_i.base_speed;
      diff_q <= 17'(e_d) - prev_eff;
    end
    case (cmd_i.op)
      OP_MUL_EDT, OP_MUL_DIFF, OP_MUL_KI, OP_MUL_KP, OP_MUL_KD: prod_q <= mul_p;
      OP_ADD: sum_q <= sum_q + prod_q[SUM_W-1:0];
      OP_OUT: begin
        if (out_free) begin
          out_data_q.correction  <= corr_q;
          out_data_q.left_speed  <= clamp_speed(left_x, min_q, max_q);
          out_data_q.right_speed <= clamp_speed(right_x, min_q, max_q);
        end
      end
      default: ;
    endcase
    if (div_start) begin
      div_neg_q <= (div_src < 0);
      div_dst_q <= cmd_i.op;
    end
    if (div_done) begin
      case (div_dst_q)
        OP_DIV_RATE: rate_q <= quo_signed[RATE_W-1:0];
        OP_DIV_KI:   sum_q  <= quo_signed[SUM_W-1:0];
        OP_DIV_SUM:  corr_q <= div_neg_q ? -$signed(corr_mag) : $signed(corr_mag);
        default: ;
      endcase
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.out_free = out_free;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

@@ sv/hhp_ctrl.sv @@
// Sequencer of the heading-hold PID: walks one tick through the datapath steps.
// Depends on hhp_pkg for the command and status structs.
module hhp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  output logic                 in_ready_o,
  input  hhp_pkg::hhp_status_t status_i,
  output hhp_pkg::hhp_cmd_t    cmd_o
);
  import hhp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_EDT,
    ST_ACC,
    ST_MUL_DIFF,
    ST_DIV_RATE,
    ST_WAIT_RATE,
    ST_MUL_KI,
    ST_DIV_KI,
    ST_WAIT_KI,
    ST_MUL_KP,
    ST_ADD_KP,
    ST_MUL_KD,
    ST_ADD_KD,
    ST_DIV_SUM,
    ST_WAIT_SUM,
    ST_OUT
  } state_e;

  state_e   state_q;
  hhp_cmd_t cmd_q;
  logic     in_ready_q;

  // The command register always holds the operation of the state being entered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q.op   <= OP_NONE;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept_i) begin
            state_q    <= ST_MUL_EDT;
            cmd_q.op   <= OP_MUL_EDT;
            in_ready_q <= 1'b0;
          end
        end
        ST_MUL_EDT: begin
          state_q  <= ST_ACC;
          cmd_q.op <= OP_ACC;
        end
        ST_ACC: begin
          state_q  <= ST_MUL_DIFF;
          cmd_q.op <= OP_MUL_DIFF;
        end
        ST_MUL_DIFF: begin
          state_q  <= ST_DIV_RATE;
          cmd_q.op <= OP_DIV_RATE;
        end
        ST_DIV_RATE: begin
          state_q  <= ST_WAIT_RATE;
          cmd_q.op <= OP_NONE;
        end
        ST_WAIT_RATE: begin
          if (status_i.div_done) begin
            state_q  <= ST_MUL_KI;
            cmd_q.op <= OP_MUL_KI;
          end
        end
        ST_MUL_KI: begin
          state_q  <= ST_DIV_KI;
          cmd_q.op <= OP_DIV_KI;
        end
        ST_DIV_KI: begin
          state_q  <= ST_WAIT_KI;
          cmd_q.op <= OP_NONE;
        end
        ST_WAIT_KI: begin
          if (status_i.div_done) begin
            state_q  <= ST_MUL_KP;
            cmd_q.op <= OP_MUL_KP;
          end
        end
        ST_MUL_KP: begin
          state_q  <= ST_ADD_KP;
          cmd_q.op <= OP_ADD;
        end
        ST_ADD_KP: begin
          state_q  <= ST_MUL_KD;
          cmd_q.op <= OP_MUL_KD;
        end
        ST_MUL_KD: begin
          state_q  <= ST_ADD_KD;
          cmd_q.op <= OP_ADD;
        end
        ST_ADD_KD: begin
          state_q  <= ST_DIV_SUM;
          cmd_q.op <= OP_DIV_SUM;
        end
        ST_DIV_SUM: begin
          state_q  <= ST_WAIT_SUM;
          cmd_q.op <= OP_NONE;
        end
        ST_WAIT_SUM: begin
          if (status_i.div_done) begin
            state_q  <= ST_OUT;
            cmd_q.op <= OP_OUT;
          end
        end
        ST_OUT: begin
          if (status_i.out_free) begin
            state_q    <= ST_IDLE;
            cmd_q.op   <= OP_NONE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= ST_IDLE;
          cmd_q.op   <= OP_NONE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready_q;
  assign cmd_o      = cmd_q;

endmodule

@@ sv/heading_hold_pid_speed_split_top.sv @@
// Top level of the heading-hold PID speed splitter.
// Depends on hhp_pkg and hhp_stream_if; instantiates hhp_ctrl and hhp_datapath.

// Each tick transfer carries a target and measured heading in centidegrees, the elapsed
// milliseconds (zero stands for 10 ms), a base PWM speed and a restart flag that clears the
// integral and the remembered error before the tick is worked. The block wraps the heading
// error once into (-18000, 18000], adds error times dt to an integral clamped to the
// integral limit, forms the derivative as the error change times 1000 over dt, and returns
// one result transfer with the correction (kp*e + ki*integral/1000 + kd*rate)/25600,
// saturated to +/-255, and the left and right wheel speeds base +/- correction clamped to
// [min_speed, max_speed]; a value below min_speed gives min_speed even when min_speed is
// above max_speed. All divisions truncate toward zero. One tick is worked at a time: the
// next tick can be taken from the cycle in which the result transfer is offered. The three
// divisions run on the shared iterative divider, which works four quotient bits per cycle
// by default; the multiplies use a single shared multiplier. The result is held in an
// output register, so a stalled result holds only the next result, not the next tick
// transfer. The gains, the integral limit and the speed limits are written through the
// configuration port; the user must do so only while the block is idle, as the block
// itself does not enforce it. Writes to indexes beyond the six registers are ignored.
module heading_hold_pid_speed_split_top #(
  parameter int unsigned DivStepBits = hhp_pkg::DIV_STEP_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hhp_stream_if.sink                     in_if,
  hhp_stream_if.source                   out_if,
  input  logic                           cfg_we_i,
  input  logic [hhp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hhp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import hhp_pkg::*;

  logic        in_ready;
  logic        in_ready_q_w;
  logic        accept;
  hhp_cmd_t    cmd;
  hhp_status_t status;
  hhp_in_t     in_data;
  hhp_out_t    out_data;
  logic        out_valid;

  // A tick is taken at every edge where valid and ready are both high.
  assign in_ready    = in_ready_q_w;
  assign accept      = in_if.valid && in_ready;
  assign in_data     = in_if.data;
  assign in_if.ready = in_ready;

  hhp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_ready_o (in_ready_q_w),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hhp_datapath #(
    .DivStepBits (DivStepBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .in_data_i   (in_data),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign out_if.valid = out_valid;
  assign out_if.data  = out_data;

endmodule
